>>> rtl/tsr_pkg.sv
// ---------------------------------------------------------------------------
// tsr_pkg: shared types and constants of the triangular row solver
// Holds the sequencer and floating-point unit state codes, the FPU request
// type, IEEE double constants and configuration register codes.
// ---------------------------------------------------------------------------
`default_nettype none

package tsr_pkg;

  // Default largest matrix order
  localparam int MAX_ORDER_DEF = 64;

  // Configuration register map (word index)
  localparam logic REG_ORDER   = 1'b0;
  localparam logic [6:0] ORDER_RESET = 7'd64;

  // Input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  // IEEE double constants
  localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [10:0] EXP_ALL1    = 11'h7FF;

  // Floating-point unit operations
  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_SUB,
    FOP_RCP
  } fpu_op_t;

  // Request from the sequencer to the floating-point unit
  typedef struct packed {
    logic    start;
    fpu_op_t op;
  } fpu_req_t;

  // Floating-point unit states
  typedef enum logic [3:0] {
    F_IDLE,
    F_MUL,
    F_ALIGN,
    F_ADD,
    F_RNORM,
    F_DIV,
    F_LZC,
    F_SHIFT,
    F_DENORM,
    F_ROUND
  } fpu_state_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_MULW,
    S_SUB,
    S_SUBW,
    S_DRD,
    S_RCP,
    S_RCPW,
    S_FIN,
    S_FINW,
    S_OUT
  } seq_state_t;

endpackage

`default_nettype wire

>>> rtl/tsr_ram.sv
// ---------------------------------------------------------------------------
// tsr_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// its value until the next read.
// ---------------------------------------------------------------------------
`default_nettype none

module tsr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/tsr_fpu.sv
// ---------------------------------------------------------------------------
// tsr_fpu: multi-cycle IEEE double unit
// Computes a*b, a-b and 1/b with round to nearest even. The product is
// built from four 53x14 partial products, the reciprocal by a restoring
// divider one quotient bit per cycle; all paths share one normalize and
// round pipeline of leading-one search, shift, denormalize and round.
// ---------------------------------------------------------------------------
`default_nettype none

module tsr_fpu (
  input  logic              clk,
  input  logic              rst_n,
  input  tsr_pkg::fpu_req_t req,
  input  logic [63:0]       op_a,
  input  logic [63:0]       op_b,
  output logic              done,
  output logic [63:0]       result
);

  import tsr_pkg::*;

  // Internal value is m * 2^(e - 1148); normalized leading one at bit 125
  fpu_state_t         state_r, state_nxt;
  logic               sa_r, sa_nxt, sb_r, sb_nxt, sgn_r, sgn_nxt;
  logic               bothz_r, bothz_nxt;
  logic [52:0]        ma_r, ma_nxt, mb_r, mb_nxt;
  logic [10:0]        dexp_r, dexp_nxt;
  logic signed [13:0] e_r, e_nxt;
  logic [127:0]       m_r, m_nxt, al_r, al_nxt;
  logic [53:0]        rem_r, rem_nxt;
  logic [6:0]         cnt_r, cnt_nxt, lead_r, lead_nxt;
  logic [63:0]        res_r, res_nxt;
  logic               done_r, done_nxt;

  // Operand classification
  logic [10:0] a_exp, b_exp, ea_in, eb_in;
  logic [52:0] ma_in, mb_in;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sa_in, sb_in;
  logic        spec_hit;
  logic [63:0] spec_val;

  assign a_exp  = op_a[62:52];
  assign b_exp  = op_b[62:52];
  assign sa_in  = op_a[63];
  assign sb_in  = op_b[63];
  assign a_nan  = (&a_exp) & (|op_a[51:0]);
  assign b_nan  = (&b_exp) & (|op_b[51:0]);
  assign a_inf  = (&a_exp) & ~(|op_a[51:0]);
  assign b_inf  = (&b_exp) & ~(|op_b[51:0]);
  assign a_zero = ~(|op_a[62:0]);
  assign b_zero = ~(|op_b[62:0]);
  assign ea_in  = (a_exp == 11'd0) ? 11'd1 : a_exp;
  assign eb_in  = (b_exp == 11'd0) ? 11'd1 : b_exp;
  assign ma_in  = {(|a_exp), op_a[51:0]};
  assign mb_in  = {(|b_exp), op_b[51:0]};

  // Special operands resolve at once
  always_comb begin
    spec_hit = 1'b1;
    spec_val = '0;
    case (req.op)
      FOP_MUL: begin
        if (a_nan) spec_val = op_a | QUIET_BIT;
        else if (b_nan) spec_val = op_b | QUIET_BIT;
        else if ((a_inf & b_zero) | (a_zero & b_inf)) spec_val = DEFAULT_NAN;
        else if (a_inf | b_inf) spec_val = {sa_in ^ sb_in, EXP_ALL1, 52'd0};
        else if (a_zero | b_zero) spec_val = {sa_in ^ sb_in, 63'd0};
        else spec_hit = 1'b0;
      end
      FOP_SUB: begin
        if (a_nan) spec_val = op_a | QUIET_BIT;
        else if (b_nan) spec_val = op_b | QUIET_BIT;
        else if (a_inf & b_inf & (sa_in == sb_in)) spec_val = DEFAULT_NAN;
        else if (a_inf) spec_val = op_a;
        else if (b_inf) spec_val = {~sb_in, op_b[62:0]};
        else spec_hit = 1'b0;
      end
      FOP_RCP: begin
        if (b_nan) spec_val = op_b | QUIET_BIT;
        else if (b_zero) spec_val = {sb_in, EXP_ALL1, 52'd0};
        else if (b_inf) spec_val = {sb_in, 63'd0};
        else spec_hit = 1'b0;
      end
      default: spec_hit = 1'b0;
    endcase
  end

  // Partial product of the multiplier
  logic [55:0]  mb_pad;
  logic [13:0]  chunk;
  logic [66:0]  pp;
  logic [127:0] pp_sh;

  assign mb_pad = {3'd0, mb_r};

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    chunk = mb_pad[13:0];
      2'd1:    chunk = mb_pad[27:14];
      2'd2:    chunk = mb_pad[41:28];
      default: chunk = mb_pad[55:42];
    endcase
    pp = ma_r * chunk;
    case (cnt_r[1:0])
      2'd0:    pp_sh = 128'(pp);
      2'd1:    pp_sh = 128'(pp) << 14;
      2'd2:    pp_sh = 128'(pp) << 28;
      default: pp_sh = 128'(pp) << 42;
    endcase
  end

  // Alignment of the smaller addend with sticky bit
  logic [6:0]   dcap;
  logic [127:0] yfull, ysh, ymask;
  logic         ylost;

  assign dcap  = (dexp_r > 11'd127) ? 7'd127 : dexp_r[6:0];
  assign yfull = {2'b00, mb_r, 73'd0};
  assign ysh   = yfull >> dcap;
  assign ymask = (128'd1 << dcap) - 128'd1;
  assign ylost = |(yfull & ymask);

  // Magnitude add and subtract
  logic [128:0] diff;
  logic [127:0] sum;

  assign diff = {1'b0, m_r} - {1'b0, al_r};
  assign sum  = m_r + al_r;

  // Divisor normalization
  logic [5:0]  lz53;
  logic [52:0] md_n;

  always_comb begin
    lz53 = '0;
    for (int i = 0; i < 53; i++) begin
      if (mb_r[i]) lz53 = 6'(52 - i);
    end
  end

  assign md_n = mb_r << lz53;

  // Restoring divider step
  logic        ge;
  logic [53:0] rsub;

  assign ge   = rem_r >= {1'b0, mb_r};
  assign rsub = ge ? (rem_r - {1'b0, mb_r}) : rem_r;

  // Leading-one search
  logic [6:0] lead;
  logic       found;

  always_comb begin
    lead  = '0;
    found = 1'b0;
    for (int i = 0; i < 128; i++) begin
      if (m_r[i]) begin
        lead  = 7'(i);
        found = 1'b1;
      end
    end
  end

  // Normalizing shift
  logic [6:0] lsh;

  assign lsh = 7'd125 - lead_r;

  // Denormalizing shift for tiny results
  logic signed [13:0] dn;
  logic [6:0]         rs;
  logic [127:0]       rmask;

  assign dn    = 14'sd1 - e_r;
  assign rs    = (dn > 14'sd127) ? 7'd127 : dn[6:0];
  assign rmask = (128'd1 << rs) - 128'd1;

  // Rounding to nearest even
  logic               rup;
  logic [53:0]        mr;
  logic [52:0]        mant;
  logic signed [13:0] e_fin;
  logic [10:0]        expf;

  always_comb begin
    rup   = m_r[72] & ((|m_r[71:0]) | m_r[73]);
    mr    = {1'b0, m_r[125:73]} + 54'(rup);
    mant  = mr[53] ? mr[53:1] : mr[52:0];
    e_fin = mr[53] ? (e_r + 14'sd1) : e_r;
    expf  = mant[52] ? e_fin[10:0] : 11'd0;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (req.start && !spec_hit) begin
          case (req.op)
            FOP_MUL: state_nxt = F_MUL;
            FOP_SUB: state_nxt = F_ALIGN;
            default: state_nxt = F_RNORM;
          endcase
        end
      end
      F_MUL:    if (cnt_r[1:0] == 2'd3) state_nxt = F_LZC;
      F_ALIGN:  state_nxt = F_ADD;
      F_ADD:    state_nxt = F_LZC;
      F_RNORM:  state_nxt = F_DIV;
      F_DIV:    if (cnt_r == 7'd0) state_nxt = F_LZC;
      F_LZC:    state_nxt = found ? F_SHIFT : F_IDLE;
      F_SHIFT:  state_nxt = F_DENORM;
      F_DENORM: state_nxt = F_ROUND;
      F_ROUND:  state_nxt = F_IDLE;
      default:  state_nxt = F_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    sgn_nxt   = sgn_r;
    bothz_nxt = bothz_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    dexp_nxt  = dexp_r;
    e_nxt     = e_r;
    m_nxt     = m_r;
    al_nxt    = al_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    lead_nxt  = lead_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (req.start) begin
          if (spec_hit) begin
            res_nxt  = spec_val;
            done_nxt = 1'b1;
          end else begin
            case (req.op)
              FOP_MUL: begin
                ma_nxt    = ma_in;
                mb_nxt    = mb_in;
                m_nxt     = '0;
                e_nxt     = $signed({3'd0, ea_in}) + $signed({3'd0, eb_in}) - 14'sd1002;
                sgn_nxt   = sa_in ^ sb_in;
                bothz_nxt = 1'b0;
                cnt_nxt   = '0;
              end
              FOP_SUB: begin
                bothz_nxt = a_zero & b_zero;
                if (eb_in > ea_in) begin
                  ma_nxt   = mb_in;
                  mb_nxt   = ma_in;
                  e_nxt    = $signed({3'd0, eb_in});
                  dexp_nxt = eb_in - ea_in;
                  sa_nxt   = ~sb_in;
                  sb_nxt   = sa_in;
                end else begin
                  ma_nxt   = ma_in;
                  mb_nxt   = mb_in;
                  e_nxt    = $signed({3'd0, ea_in});
                  dexp_nxt = ea_in - eb_in;
                  sa_nxt   = sa_in;
                  sb_nxt   = ~sb_in;
                end
              end
              default: begin
                mb_nxt    = mb_in;
                e_nxt     = 14'sd2110 - $signed({3'd0, eb_in});
                sgn_nxt   = sb_in;
                bothz_nxt = 1'b0;
              end
            endcase
          end
        end
      end
      F_MUL: begin
        m_nxt   = m_r + pp_sh;
        cnt_nxt = cnt_r + 7'd1;
      end
      F_ALIGN: begin
        m_nxt  = {2'b00, ma_r, 73'd0};
        al_nxt = ysh | 128'(ylost);
      end
      F_ADD: begin
        if (sa_r == sb_r) begin
          m_nxt   = sum;
          sgn_nxt = sa_r;
        end else if (diff[128]) begin
          m_nxt   = 128'(~diff + 129'd1);
          sgn_nxt = sb_r;
        end else begin
          m_nxt   = diff[127:0];
          sgn_nxt = sa_r;
        end
      end
      F_RNORM: begin
        mb_nxt  = md_n;
        e_nxt   = e_r + $signed({8'd0, lz53});
        rem_nxt = 54'd1 << 52;
        cnt_nxt = 7'd60;
        m_nxt   = '0;
      end
      F_DIV: begin
        rem_nxt = {rsub[52:0], 1'b0};
        if (cnt_r == 7'd0) begin
          m_nxt = {m_r[125:0], ge, (|rsub)};
        end else begin
          m_nxt   = {m_r[126:0], ge};
          cnt_nxt = cnt_r - 7'd1;
        end
      end
      F_LZC: begin
        lead_nxt = lead;
        if (!found) begin
          // Exact zero: positive unless a subtract of two zeros has a negative a and a positive b
          res_nxt  = {bothz_r & sa_r & sb_r, 63'd0};
          done_nxt = 1'b1;
        end
      end
      F_SHIFT: begin
        if (lead_r == 7'd126) begin
          m_nxt = (m_r >> 1) | 128'(m_r[0]);
          e_nxt = e_r + 14'sd1;
        end else begin
          m_nxt = m_r << lsh;
          e_nxt = e_r - $signed({7'd0, lsh});
        end
      end
      F_DENORM: begin
        if (e_r < 14'sd1) begin
          m_nxt = (m_r >> rs) | 128'(|(m_r & rmask));
          e_nxt = 14'sd1;
        end
      end
      F_ROUND: begin
        if (e_fin >= 14'sd2047) begin
          res_nxt = {sgn_r, EXP_ALL1, 52'd0};
        end else begin
          res_nxt = {sgn_r, expf, mant[51:0]};
        end
        done_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sa_r    <= sa_nxt;
    sb_r    <= sb_nxt;
    sgn_r   <= sgn_nxt;
    bothz_r <= bothz_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    dexp_r  <= dexp_nxt;
    e_r     <= e_nxt;
    m_r     <= m_nxt;
    al_r    <= al_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    lead_r  <= lead_nxt;
    res_r   <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

>>> rtl/triangular_solve_row_stream.sv
// ---------------------------------------------------------------------------
// triangular_solve_row_stream: streaming solver of X * A^T = B
// A lower-triangular A in double precision is loaded entry by entry into
// an on-chip RAM; elements of B then stream in row by row and each yields
// one solved element x.
//
//   Channel  Direction  Beat content
//   in_      slave      tuser: command; tdata: row, column, value
//   out_     master     tdata: x value, column; tlast: last column of row
//   cfg_     APB        register 0: matrix order
//
// Load beats are accepted back to back while the solver is idle. Every
// elimination step of a B element is a multiply and a subtract on the
// one shared FPU, and the reciprocal of the diagonal runs through its
// restoring divider. Special operands finish their FPU operation early.
// Reset is synchronous and sets the order to 64 and the column position
// to 0; the RAMs are not cleared. A result waiting on out_ does not
// block the next input beat.
// ---------------------------------------------------------------------------
`default_nettype none

module triangular_solve_row_stream #(
  parameter int MAX_ORDER = tsr_pkg::MAX_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // row_index[5:0], col_index[11:6], value[75:12]
  input  logic        in_tuser,   // command[0]
  // Result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // x_value[63:0], column[69:64]
  output logic        out_tlast,
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  import tsr_pkg::*;

  localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int LA    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  seq_state_t     state_r, state_nxt;
  logic [6:0]     order_r, order_nxt;
  logic [IW-1:0]  colpos_r, colpos_nxt, j_r, j_nxt, k_r, k_nxt;
  logic           last_r, last_nxt;
  logic [63:0]    acc_r, acc_nxt, prod_r, prod_nxt, recip_r, recip_nxt, x_r, x_nxt;
  logic           out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [63:0]    out_x_r, out_x_nxt;
  logic [5:0]     out_col_r, out_col_nxt;

  // Input fields
  logic        in_cmd;
  logic [5:0]  in_row, in_col;
  logic [63:0] in_value;
  logic        in_acc;

  assign in_cmd   = in_tuser;
  assign in_row   = in_tdata[5:0];
  assign in_col   = in_tdata[11:6];
  assign in_value = in_tdata[75:12];
  assign in_acc   = in_tvalid & in_tready;

  // Configuration write
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ORDER) ? {25'd0, order_r} : 32'd0;

  // Effective order and column of a new element
  logic [8:0]    ord9, n9, cp9, j9;
  logic [IW-1:0] j_in;
  logic          last_in;

  always_comb begin
    ord9    = (order_r == 7'd0) ? 9'd1 : {2'b00, order_r};
    n9      = (ord9 > 9'(MAX_ORDER)) ? 9'(MAX_ORDER) : ord9;
    cp9     = 9'(colpos_r);
    j9      = (cp9 >= n9) ? (n9 - 9'd1) : cp9;
    j_in    = j9[IW-1:0];
    last_in = (j9 + 9'd1) >= n9;
  end

  // Load address decode
  logic         ld_ok;
  logic [LA-1:0] ld_addr;

  assign ld_ok   = (9'(in_row) < 9'(MAX_ORDER)) && (9'(in_col) < 9'(MAX_ORDER))
                   && (in_col <= in_row);
  assign ld_addr = LA'(17'(in_row) * 17'(MAX_ORDER) + 17'(in_col));

  // Read addresses of the elimination loop
  logic [LA-1:0] off_addr, diag_addr;

  assign off_addr  = LA'(17'(j_r) * 17'(MAX_ORDER) + 17'(k_r));
  assign diag_addr = LA'(17'(j_r) * 17'(MAX_ORDER) + 17'(j_r));

  logic out_free;
  assign out_free = ~out_valid_r | out_tready;

  // Memory and FPU hookup
  logic          low_we, low_re, row_we, row_re;
  logic [LA-1:0] low_waddr, low_raddr;
  logic [63:0]   low_rdata, row_rdata;
  fpu_req_t      fpu_req;
  logic [63:0]   fpu_a, fpu_b, fpu_res;
  logic          fpu_done;

  tsr_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_lower (
    .clk   (clk),
    .we    (low_we),
    .waddr (low_waddr),
    .wdata (in_value),
    .re    (low_re),
    .raddr (low_raddr),
    .rdata (low_rdata)
  );

  tsr_ram #(.WIDTH(64), .DEPTH(MAX_ORDER)) u_row (
    .clk   (clk),
    .we    (row_we),
    .waddr (j_r),
    .wdata (x_r),
    .re    (row_re),
    .raddr (k_r),
    .rdata (row_rdata)
  );

  tsr_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (fpu_req),
    .op_a   (fpu_a),
    .op_b   (fpu_b),
    .done   (fpu_done),
    .result (fpu_res)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == CMD_SOLVE)) begin
          state_nxt = (j_in == '0) ? S_DRD : S_RD;
        end
      end
      S_RD:   state_nxt = S_MUL;
      S_MUL:  state_nxt = S_MULW;
      S_MULW: if (fpu_done) state_nxt = S_SUB;
      S_SUB:  state_nxt = S_SUBW;
      S_SUBW: begin
        if (fpu_done) begin
          state_nxt = ((9'(k_r) + 9'd1) == 9'(j_r)) ? S_DRD : S_RD;
        end
      end
      S_DRD:  state_nxt = S_RCP;
      S_RCP:  state_nxt = S_RCPW;
      S_RCPW: if (fpu_done) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_FINW;
      S_FINW: if (fpu_done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs: handshake, memory ports and FPU requests
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    low_we        = in_acc & (in_cmd == CMD_LOAD) & ld_ok;
    low_waddr     = ld_addr;
    low_re        = (state_r inside {S_RD, S_DRD});
    low_raddr     = (state_r == S_DRD) ? diag_addr : off_addr;
    row_re        = (state_r == S_RD);
    row_we        = (state_r == S_OUT) & out_free;
    fpu_req.start = (state_r inside {S_MUL, S_SUB, S_RCP, S_FIN});
    fpu_req.op    = FOP_MUL;
    fpu_a         = acc_r;
    fpu_b         = recip_r;
    case (state_r)
      S_MUL: begin
        fpu_a = row_rdata;
        fpu_b = low_rdata;
      end
      S_SUB: begin
        fpu_req.op = FOP_SUB;
        fpu_b      = prod_r;
      end
      S_RCP: begin
        fpu_req.op = FOP_RCP;
        fpu_b      = low_rdata;
      end
      default: ;
    endcase
  end

  // Register updates
  always_comb begin
    order_nxt     = order_r;
    colpos_nxt    = colpos_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    recip_nxt     = recip_r;
    x_nxt         = x_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_x_nxt     = out_x_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_cmd == CMD_SOLVE)) begin
          j_nxt    = j_in;
          k_nxt    = '0;
          last_nxt = last_in;
          acc_nxt  = in_value;
        end
      end
      S_MULW: if (fpu_done) prod_nxt = fpu_res;
      S_SUBW: begin
        if (fpu_done) begin
          acc_nxt = fpu_res;
          k_nxt   = k_r + IW'(1);
        end
      end
      S_RCPW: if (fpu_done) recip_nxt = fpu_res;
      S_FINW: if (fpu_done) x_nxt = fpu_res;
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = x_r;
          out_col_nxt   = 6'(j_r);
          out_last_nxt  = last_r;
          colpos_nxt    = last_r ? '0 : IW'(9'(j_r) + 9'd1);
        end
      end
      default: ;
    endcase
    // Writing the order starts a new row
    if (cfg_wr && (cfg_paddr[2] == REG_ORDER)) begin
      order_nxt  = cfg_pwdata[6:0];
      colpos_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      order_r     <= ORDER_RESET;
      colpos_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      order_r     <= order_nxt;
      colpos_r    <= colpos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    last_r     <= last_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    recip_r    <= recip_nxt;
    x_r        <= x_nxt;
    out_x_r    <= out_x_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_col_r, out_x_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
